@@ src/clt_pkg.sv @@
// shared types, character codes and result codes of the config line tokenizer
package clt_pkg;

    localparam int MAX_TOKENS_DEF = 64;
    localparam int TOKEN_INDEX_W  = 6;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    typedef enum logic [2:0] {
        PH_LEAD         = 3'd0,
        PH_KW_BARE      = 3'd1,
        PH_KW_QUOTED    = 3'd2,
        PH_AFTER_KW     = 3'd3,
        PH_ARGS         = 3'd4,
        PH_ARG_COMMENT  = 3'd5,
        PH_LINE_COMMENT = 3'd6,
        PH_DEAD         = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2
    } t_quote;

    typedef enum logic [2:0] {
        ST_BLANK      = 3'd0,
        ST_DIRECTIVE  = 3'd1,
        ST_UNTERM_KW  = 3'd2,
        ST_EMPTY_KW   = 3'd3,
        ST_OPEN_QUOTE = 3'd4,
        ST_TOO_MANY   = 3'd5
    } t_status;

    // line context without the token counter (its width follows the parameter)
    typedef struct packed {
        t_phase  phase;
        logic    esc;
        t_quote  quote;
        logic    open;
        t_status err;
    } t_ctx;

    typedef struct packed {
        logic [7:0] char_in;
        logic       byte_valid;
        logic       last_of_line;
    } t_in;

    typedef struct packed {
        logic [7:0]               char_out;
        logic                     char_valid;
        logic [TOKEN_INDEX_W-1:0] token_index;
        logic                     token_end;
        logic                     end_closes_token;
        logic                     line_done;
        logic [2:0]               status;
    } t_out;

endpackage

@@ src/config_line_tokenizer_core.sv @@
// top level of the config line tokenizer: input register, byte decision, result register
//
//  channel | valid      | stall      | payload     | transfer when
//  --------+------------+------------+-------------+------------------------------
//  input   | i_in_valid | o_in_stall | i_in_data   | i_in_valid high, o_in_stall low
//  output  | o_out_valid| i_out_stall| o_out_data  | o_out_valid high, i_out_stall low
//
// one byte per cycle sustained while the output is not stalled; a byte passes through the
// input register and then the result register before its result is on the output
// the rate is set by the line context update in clt_step, done once per byte
// i_rst_n (synchronous, active low) empties both registers and returns the line context
// to leading whitespace with no tokens
// a stalled output holds its result; the input register keeps taking a byte while the
// output is full as long as its own byte can move on, otherwise o_in_stall rises
module config_line_tokenizer_core #(
    parameter int MAX_TOKENS = clt_pkg::MAX_TOKENS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  clt_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output clt_pkg::t_out o_out_data
);
    import clt_pkg::*;

    localparam int CAP   = (MAX_TOKENS < 64) ? MAX_TOKENS : 64;
    localparam int CNT_W = $clog2(CAP + 1);

    // input register
    logic             r_in_valid;
    t_in              r_in;
    // line context, updated once per byte as it moves to the result register
    t_ctx             r_ctx;
    t_ctx             n_ctx;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    // result register
    logic             r_out_valid;
    t_out             r_out;
    t_out             n_out;

    logic             in_xfer;
    logic             advance;

    // the held byte moves on when the result register is empty or being drained
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    clt_step #(
        .MAX_TOKENS (MAX_TOKENS),
        .CNT_W      (CNT_W)
    ) u_step (
        .i_item (r_in),
        .i_ctx  (r_ctx),
        .i_cnt  (r_cnt),
        .o_ctx  (n_ctx),
        .o_cnt  (n_cnt),
        .o_res  (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctx.phase <= PH_LEAD;
            r_ctx.esc   <= 1'b0;
            r_ctx.quote <= Q_NONE;
            r_ctx.open  <= 1'b0;
            r_ctx.err   <= ST_BLANK;
            r_cnt       <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_ctx       <= n_ctx;
                r_cnt       <= n_cnt;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a finished line leaves the context at its start
    a_line_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_out.line_done |=> (r_ctx.phase == PH_LEAD) && (r_cnt == '0)
        && !r_ctx.open)
        else $error("context not cleared after line end");

    // the token counter never passes its cap
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAP))
        else $error("token counter above cap");

    // a byte never both adds a character and closes a token
    a_char_or_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.char_valid && r_out.token_end))
        else $error("character and token end in one result");

    // an end close only comes with a directive or too-many status
    a_end_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.end_closes_token |->
        r_out.line_done && ((r_out.status == ST_DIRECTIVE) || (r_out.status == ST_TOO_MANY)))
        else $error("end close with wrong status");

endmodule

@@ src/clt_step.sv @@
// per-byte decision logic: next line context and the result of one byte
module clt_step #(
    parameter int MAX_TOKENS = clt_pkg::MAX_TOKENS_DEF,
    parameter int CNT_W      = 7
) (
    input  clt_pkg::t_in       i_item,
    input  clt_pkg::t_ctx      i_ctx,
    input  logic [CNT_W-1:0]   i_cnt,
    output clt_pkg::t_ctx      o_ctx,
    output logic [CNT_W-1:0]   o_cnt,
    output clt_pkg::t_out      o_res
);
    import clt_pkg::*;

    localparam int CAP = (MAX_TOKENS < 64) ? MAX_TOKENS : 64;

    logic [7:0]       c;
    logic             ws;
    logic             arg_go;
    logic             do_emit;
    logic             do_open;
    logic             do_close;
    logic             open_now;
    logic             opn;
    logic             esc;
    t_phase           ph;
    t_quote           qk;
    t_status          err;
    t_status          st;
    logic [7:0]       qc;
    logic [CNT_W-1:0] cnt;
    logic [7:0]       idx_wide;

    assign c  = i_item.char_in;
    assign ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

    always_comb begin
        ph       = i_ctx.phase;
        esc      = i_ctx.esc;
        qk       = i_ctx.quote;
        err      = i_ctx.err;
        arg_go   = 1'b0;
        do_emit  = 1'b0;
        do_open  = 1'b0;
        do_close = 1'b0;
        qc       = (i_ctx.quote == Q_SINGLE) ? CH_SQUOTE : CH_DQUOTE;

        if (i_item.byte_valid) begin
            unique case (i_ctx.phase)
                PH_LEAD: begin
                    if (!ws) begin
                        if (c == CH_HASH) begin
                            ph = PH_LINE_COMMENT;
                        end else if (c == CH_EQ) begin
                            err = ST_EMPTY_KW;
                            ph  = PH_DEAD;
                        end else if (c == CH_DQUOTE) begin
                            ph = PH_KW_QUOTED;
                        end else begin
                            do_emit = 1'b1;
                            ph      = PH_KW_BARE;
                        end
                    end
                end
                PH_KW_BARE: begin
                    if (ws) begin
                        do_close = 1'b1;
                        ph       = PH_AFTER_KW;
                    end else if (c == CH_EQ) begin
                        do_close = 1'b1;
                        ph       = PH_ARGS;
                    end else begin
                        do_emit = 1'b1;
                    end
                end
                PH_KW_QUOTED: begin
                    if (c == CH_DQUOTE) begin
                        if (i_ctx.open) begin
                            do_close = 1'b1;
                            ph       = PH_AFTER_KW;
                        end else begin
                            err = ST_EMPTY_KW;
                            ph  = PH_DEAD;
                        end
                    end else begin
                        do_emit = 1'b1;
                    end
                end
                PH_AFTER_KW: begin
                    if (!ws) begin
                        ph     = PH_ARGS;
                        arg_go = (c != CH_EQ);
                    end
                end
                PH_ARGS: begin
                    arg_go = 1'b1;
                end
                default: begin
                end
            endcase

            // argument byte: escapes, quotes, comments, separators
            if (arg_go) begin
                if (i_ctx.esc) begin
                    do_emit = 1'b1;
                    esc     = 1'b0;
                end else if ((c == CH_BSLASH) && (i_ctx.quote != Q_SINGLE)) begin
                    esc     = 1'b1;
                    do_open = 1'b1;
                end else if (i_ctx.quote != Q_NONE) begin
                    if (c == qc) begin
                        qk = Q_NONE;
                    end else begin
                        do_emit = 1'b1;
                    end
                end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
                    qk      = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
                    do_open = 1'b1;
                end else if (c == CH_HASH) begin
                    ph = PH_ARG_COMMENT;
                end else if (ws) begin
                    do_close = i_ctx.open;
                end else begin
                    do_emit = 1'b1;
                end
            end
        end

        // token start and index saturation
        open_now = (do_emit || do_open) && !i_ctx.open;
        cnt      = i_cnt;
        if (open_now) begin
            if (i_cnt < CNT_W'(CAP)) begin
                cnt = i_cnt + CNT_W'(1);
            end else if (err == ST_BLANK) begin
                err = ST_TOO_MANY;
            end
        end
        opn = do_close ? 1'b0 : ((do_emit || do_open) ? 1'b1 : i_ctx.open);

        idx_wide = 8'(cnt) - 8'd1;

        o_res = '0;
        if (do_emit) begin
            o_res.char_out    = c;
            o_res.char_valid  = 1'b1;
            o_res.token_index = idx_wide[TOKEN_INDEX_W-1:0];
        end
        if (do_close) begin
            o_res.token_end   = 1'b1;
            o_res.token_index = idx_wide[TOKEN_INDEX_W-1:0];
        end

        o_ctx.phase = ph;
        o_ctx.esc   = esc;
        o_ctx.quote = qk;
        o_ctx.open  = opn;
        o_ctx.err   = err;
        o_cnt       = cnt;

        // line end: status, closing of an open token, context back to start
        st = ST_BLANK;
        if (i_item.last_of_line) begin
            if (err == ST_EMPTY_KW) begin
                st = ST_EMPTY_KW;
            end else if (ph == PH_KW_QUOTED) begin
                st = ST_UNTERM_KW;
            end else if ((ph == PH_LEAD) || (ph == PH_LINE_COMMENT)) begin
                st = ST_BLANK;
            end else if (esc || (qk != Q_NONE)) begin
                st = ST_OPEN_QUOTE;
            end else if (err == ST_TOO_MANY) begin
                st = ST_TOO_MANY;
            end else begin
                st = ST_DIRECTIVE;
            end
            o_res.line_done = 1'b1;
            o_res.status    = st;
            if (((st == ST_DIRECTIVE) || (st == ST_TOO_MANY)) && opn) begin
                o_res.end_closes_token = 1'b1;
                o_res.token_index      = idx_wide[TOKEN_INDEX_W-1:0];
            end
            o_ctx.phase = PH_LEAD;
            o_ctx.esc   = 1'b0;
            o_ctx.quote = Q_NONE;
            o_ctx.open  = 1'b0;
            o_ctx.err   = ST_BLANK;
            o_cnt       = '0;
        end
    end

endmodule
